// ----- design/difference_table_stego_embed_extract_core_macros.svh -----
// Assertion macros shared by the difference table steganography core.
`ifndef DIFFERENCE_TABLE_STEGO_EMBED_EXTRACT_CORE_MACROS_SVH
`define DIFFERENCE_TABLE_STEGO_EMBED_EXTRACT_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DTS_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DTS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- design/dts_pkg.sv -----
// Shared constants, control structs and key table lookup for the stego core.
package dts_pkg;

  localparam int KEY_WORDS     = 8;
  localparam int WORD_W        = 64;
  localparam int KEY_BITS      = KEY_WORDS * WORD_W;
  localparam int KEY_SEL_W     = $clog2(KEY_WORDS);
  localparam int CFG_INDEX_W   = 4;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 9;
  localparam int DIST_W        = 9;
  localparam int SUM_W         = 11;
  localparam int MAX_DIST      = 255;
  localparam int BYTE_MAX      = 255;
  localparam int DIFF_OFFSET   = 255;
  localparam int DEFAULT_LANES = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic check;
    logic step;
    logic emit;
  } dts_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic keep;
    logic found;
    logic last;
  } dts_sts_t;

  // One bit of the key table; entry i is bit i of the flattened key words.
  function automatic logic table_bit(input logic [KEY_BITS-1:0] key,
                                     input logic [IDX_W-1:0]    idx);
    return key[idx];
  endfunction

endpackage

// ----- design/dts_stream_if.sv -----
// Valid/ready stream interfaces for the cover byte input and the result output.
interface dts_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic                       restart;
  logic [dts_pkg::BYTE_W-1:0] cover_byte;
  logic                       message_bit;

  modport source (output valid, mode, restart, cover_byte, message_bit, input ready);
  modport sink   (input valid, mode, restart, cover_byte, message_bit, output ready);
endinterface

interface dts_out_if;
  logic                       valid;
  logic                       ready;
  logic [dts_pkg::BYTE_W-1:0] out_byte;
  logic                       read_bit;
  logic                       changed;
  logic                       failed;

  modport source (output valid, out_byte, read_bit, changed, failed, input ready);
  modport sink   (input valid, out_byte, read_bit, changed, failed, output ready);
endinterface

// ----- design/dts_datapath.sv -----
// Datapath: key table, previous byte, lane-parallel distance search and result registers.
module dts_datapath #(
  parameter int LANES = dts_pkg::DEFAULT_LANES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dts_pkg::WORD_W-1:0]      cfg_data,
  input  logic                            in_mode,
  input  logic                            in_restart,
  input  logic [dts_pkg::BYTE_W-1:0]      in_cover_byte,
  input  logic                            in_message_bit,
  input  dts_pkg::dts_cmd_t               cmd,
  output dts_pkg::dts_sts_t               sts,
  output logic [dts_pkg::BYTE_W-1:0]      out_byte,
  output logic                            read_bit,
  output logic                            changed,
  output logic                            failed
);

  localparam int SUM_W  = dts_pkg::SUM_W;
  localparam int BYTE_W = dts_pkg::BYTE_W;
  localparam int IDX_W  = dts_pkg::IDX_W;
  localparam int DIST_W = dts_pkg::DIST_W;

  logic [dts_pkg::KEY_WORDS-1:0][dts_pkg::WORD_W-1:0] key;
  logic [BYTE_W-1:0] prev;
  logic              mode_r;
  logic              want_r;
  logic [BYTE_W-1:0] cover_r;
  logic [DIST_W-1:0] base;
  logic [BYTE_W-1:0] res_byte;
  logic              res_rbit;
  logic              res_changed;
  logic              res_failed;

  logic [SUM_W-1:0]  cover_w;
  logic [SUM_W-1:0]  prev_w;
  logic [SUM_W-1:0]  d0;
  logic              bit0;

  logic [LANES-1:0]  up_hit;
  logic [LANES-1:0]  down_hit;
  logic [BYTE_W-1:0] up_byte   [LANES];
  logic [BYTE_W-1:0] down_byte [LANES];
  logic [BYTE_W-1:0] sel_byte;
  logic              found;

  // Key words are written from the configuration port; indexes past the table are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_we && (cfg_index < dts_pkg::CFG_INDEX_W'(dts_pkg::KEY_WORDS))) begin
      key[cfg_index[dts_pkg::KEY_SEL_W-1:0]] <= cfg_data;
    end
  end

  assign cover_w = SUM_W'(cover_r);
  assign prev_w  = SUM_W'(prev);

  // Difference index of the unchanged cover byte.
  assign d0   = cover_w + SUM_W'(dts_pkg::DIFF_OFFSET) - prev_w;
  assign bit0 = dts_pkg::table_bit(key, d0[IDX_W-1:0]);

  // One lane per distance in the current group: try cover + k and cover - k.
  always_comb begin
    for (int j = 0; j < LANES; j++) begin
      logic [SUM_W-1:0] span;
      logic [SUM_W-1:0] up_val;
      logic [SUM_W-1:0] up_idx;
      logic [SUM_W-1:0] down_idx;
      span         = SUM_W'(base) + SUM_W'(j);
      up_val       = cover_w + span;
      up_idx       = up_val + SUM_W'(dts_pkg::DIFF_OFFSET) - prev_w;
      down_idx     = cover_w + SUM_W'(dts_pkg::DIFF_OFFSET) - prev_w - span;
      up_byte[j]   = up_val[BYTE_W-1:0];
      down_byte[j] = cover_r - span[BYTE_W-1:0];
      up_hit[j]    = (up_val <= SUM_W'(dts_pkg::BYTE_MAX)) &&
                     (dts_pkg::table_bit(key, up_idx[IDX_W-1:0]) == want_r);
      down_hit[j]  = (span <= cover_w) &&
                     (dts_pkg::table_bit(key, down_idx[IDX_W-1:0]) == want_r);
    end
  end

  // Nearest distance wins; at equal distance the upward candidate wins.
  always_comb begin
    sel_byte = cover_r;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (down_hit[j]) begin
        sel_byte = down_byte[j];
      end
      if (up_hit[j]) begin
        sel_byte = up_byte[j];
      end
    end
  end

  assign found = |{up_hit, down_hit};

  assign sts.keep  = mode_r || (bit0 == want_r);
  assign sts.found = found;
  assign sts.last  = (SUM_W'(base) + SUM_W'(LANES)) > SUM_W'(dts_pkg::MAX_DIST);

  // Previous byte: cleared by restart at the input beat, replaced by each result.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (cmd.accept && in_restart) begin
      prev <= '0;
    end else if (cmd.emit) begin
      prev <= res_byte;
    end
  end

  // Item registers and search progress.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r  <= in_mode;
      want_r  <= in_message_bit;
      cover_r <= in_cover_byte;
    end
    if (cmd.check) begin
      base        <= DIST_W'(1);
      res_byte    <= cover_r;
      res_rbit    <= mode_r & bit0;
      res_changed <= 1'b0;
      res_failed  <= 1'b0;
    end else if (cmd.step) begin
      base <= base + DIST_W'(LANES);
      if (found) begin
        res_byte    <= sel_byte;
        res_changed <= 1'b1;
      end else if (sts.last) begin
        res_failed <= 1'b1;
      end
    end
  end

  // Output register, loaded when the result beat slot is free.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_byte <= res_byte;
      read_bit <= res_rbit;
      changed  <= res_changed;
      failed   <= res_failed;
    end
  end

endmodule

// ----- design/dts_controller.sv -----
// Controller: sequences accept, table check, distance search and result hand-off.
module dts_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dts_pkg::dts_sts_t sts,
  output dts_pkg::dts_cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_SEARCH = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.keep ? S_EMIT : S_SEARCH;
      end
      S_SEARCH: begin
        cmd.step = 1'b1;
        if (sts.found || sts.last) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Result beat stays valid until taken; a new one is loaded only into a free slot.
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- design/difference_table_stego_embed_extract_core.sv -----
// Top level of the difference table steganography embed and extract core.
//
// Each input beat carries one cover byte; one result beat comes back for it. The
// core works on one byte at a time: the beat is taken in the idle state, the key
// table bit at the byte's own difference is checked in the next, and in extract
// mode or when that bit already matches the message bit the result goes to the
// emit state, where it is loaded into the output register once the slot is free.
// Otherwise the outward search checks LANES distances per cycle (eight by
// default), both directions of each, and then the result goes to the emit state.
// A finished result waits in the output register while the next byte is taken.
// The user is to write the eight 64-bit key words through the configuration port
// while the core is idle; the core itself does not enforce this. Writes to indexes
// past the last key word are ignored.
`include "difference_table_stego_embed_extract_core_macros.svh"

module difference_table_stego_embed_extract_core #(
  parameter int LANES = dts_pkg::DEFAULT_LANES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [dts_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dts_pkg::WORD_W-1:0]      cfg_data,
  dts_in_if.sink                          in_ch,
  dts_out_if.source                       out_ch
);

  dts_pkg::dts_cmd_t cmd;
  dts_pkg::dts_sts_t sts;

  // Control sequencing.
  dts_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Key table, search lanes and result registers.
  dts_datapath #(
    .LANES (LANES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (in_ch.mode),
    .in_restart     (in_ch.restart),
    .in_cover_byte  (in_ch.cover_byte),
    .in_message_bit (in_ch.message_bit),
    .cmd            (cmd),
    .sts            (sts),
    .out_byte       (out_ch.out_byte),
    .read_bit       (out_ch.read_bit),
    .changed        (out_ch.changed),
    .failed         (out_ch.failed)
  );

  // No second input beat is taken while a byte is in progress.
  `DTS_ASSERT_NEXT(a_one_at_a_time, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken mid-item")
  // A result is loaded only when the output slot is free.
  `DTS_ASSERT_NOW(a_emit_free_slot, cmd.emit, !out_ch.valid || out_ch.ready, "result overwritten")
  // A loaded result shows as a valid beat in the next cycle.
  `DTS_ASSERT_NEXT(a_emit_shows, cmd.emit, out_ch.valid, "result not presented")

endmodule

// ----- tb/sv/difference_table_stego_embed_extract_core_tb.sv -----
// Self-checking testbench for the difference table steganography embed and extract core.
module difference_table_stego_embed_extract_core_tb;

  localparam logic MODE_EMBED      = 1'b0;
  localparam logic MODE_EXTRACT    = 1'b1;
  localparam int   HOLD_OFF_CYCLES = 300;
  localparam int   SETTLE_CYCLES   = 40;
  localparam int   CYCLE_LIMIT     = 500000;
  localparam int   MAX_REPORTS     = 100;
  localparam int   PRESSURE_PHASE  = 0;
  localparam int   NUM_ROWS        = 19;
  localparam int   NUM_PHASES      = 8;
  localparam int   BYTE_W          = dts_pkg::BYTE_W;
  localparam int   WORD_W          = dts_pkg::WORD_W;
  localparam int   CFG_INDEX_W     = dts_pkg::CFG_INDEX_W;
  localparam int   KEY_WORDS       = dts_pkg::KEY_WORDS;

  typedef enum int {
    KEY_ZERO, KEY_ONES, KEY_ALTERNATE, KEY_LOWEST, KEY_HIGHEST,
    KEY_RANDOM, KEY_SPARSE, KEY_DENSE
  } key_pattern_t;

  typedef struct packed {
    logic              mode;
    logic              restart;
    logic [BYTE_W-1:0] cover_byte;
    logic              message_bit;
  } cover_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              read_bit;
    logic              changed;
    logic              failed;
  } stego_result_t;

  typedef struct {
    key_pattern_t  key;
    logic          mode;
    logic          restart;
    logic [7:0]    cover_byte;
    logic          message_bit;
    bit            typed;
    stego_result_t result;
  } directed_row_t;

  typedef struct {
    key_pattern_t key;
    int           beats;
    int           idle_pct;
  } phase_t;

  logic clk = 1'b0;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [WORD_W-1:0]      cfg_data;

  dts_in_if  in_ch();
  dts_out_if out_ch();

  difference_table_stego_embed_extract_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Predictor state: our own copy of the key table and the last emitted byte.
  logic [dts_pkg::KEY_BITS-1:0] key_table = '0;
  logic [BYTE_W-1:0]   last_out_byte = '0;
  stego_result_t       expected_results [$];
  int                  mismatches = 0;
  int                  idle_pct = 0;
  bit                  hold_off_req = 1'b0;

  // Directed rows: typed results only where the key makes them obvious.
  directed_row_t directed_rows [0:NUM_ROWS-1] = '{
    '{KEY_ZERO,      MODE_EXTRACT, 1'b0, 8'd0,   1'b0, 1'b1, '{8'd0,   1'b0, 1'b0, 1'b0}},
    '{KEY_ZERO,      MODE_EXTRACT, 1'b0, 8'd255, 1'b1, 1'b1, '{8'd255, 1'b0, 1'b0, 1'b0}},
    '{KEY_ZERO,      MODE_EMBED,   1'b0, 8'd128, 1'b0, 1'b1, '{8'd128, 1'b0, 1'b0, 1'b0}},
    '{KEY_ZERO,      MODE_EMBED,   1'b0, 8'd0,   1'b1, 1'b1, '{8'd0,   1'b0, 1'b0, 1'b1}},
    '{KEY_ZERO,      MODE_EMBED,   1'b1, 8'd255, 1'b1, 1'b1, '{8'd255, 1'b0, 1'b0, 1'b1}},
    '{KEY_ONES,      MODE_EXTRACT, 1'b1, 8'd77,  1'b0, 1'b1, '{8'd77,  1'b1, 1'b0, 1'b0}},
    '{KEY_ONES,      MODE_EMBED,   1'b0, 8'd200, 1'b0, 1'b1, '{8'd200, 1'b0, 1'b0, 1'b1}},
    '{KEY_ONES,      MODE_EMBED,   1'b1, 8'd0,   1'b1, 1'b1, '{8'd0,   1'b0, 1'b0, 1'b0}},
    '{KEY_ONES,      MODE_EMBED,   1'b0, 8'd255, 1'b1, 1'b1, '{8'd255, 1'b0, 1'b0, 1'b0}},
    '{KEY_ALTERNATE, MODE_EMBED,   1'b1, 8'd0,   1'b0, 1'b0, '0},
    '{KEY_ALTERNATE, MODE_EMBED,   1'b1, 8'd100, 1'b0, 1'b0, '0},
    '{KEY_ALTERNATE, MODE_EMBED,   1'b1, 8'd255, 1'b1, 1'b0, '0},
    '{KEY_ALTERNATE, MODE_EXTRACT, 1'b0, 8'd37,  1'b1, 1'b0, '0},
    '{KEY_LOWEST,    MODE_EXTRACT, 1'b1, 8'd255, 1'b0, 1'b0, '0},
    '{KEY_LOWEST,    MODE_EMBED,   1'b0, 8'd200, 1'b1, 1'b0, '0},
    '{KEY_LOWEST,    MODE_EMBED,   1'b1, 8'd0,   1'b1, 1'b0, '0},
    '{KEY_HIGHEST,   MODE_EMBED,   1'b1, 8'd0,   1'b1, 1'b0, '0},
    '{KEY_HIGHEST,   MODE_EMBED,   1'b0, 8'd10,  1'b0, 1'b0, '0},
    '{KEY_HIGHEST,   MODE_EXTRACT, 1'b1, 8'd255, 1'b0, 1'b0, '0}
  };

  // Random phases; the last one runs without any idling.
  phase_t phase_plan [0:NUM_PHASES-1] = '{
    '{KEY_RANDOM, 150, 20}, '{KEY_SPARSE, 150, 30}, '{KEY_DENSE, 120, 0},
    '{KEY_ZERO, 40, 20},    '{KEY_ONES, 40, 20},    '{KEY_LOWEST, 40, 15},
    '{KEY_RANDOM, 150, 25}, '{KEY_RANDOM, 160, 0}
  };

  // Clock: period of four time units.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Key table entry for a candidate byte against the last emitted byte.
  function automatic logic key_entry(input int byte_val);
    return key_table[byte_val + dts_pkg::DIFF_OFFSET - int'(last_out_byte)];
  endfunction

  // Works out the result of one cover byte and advances the predictor state.
  function automatic stego_result_t predict_stego(input cover_beat_t beat);
    stego_result_t res;
    int base;
    int k;
    bit hit;
    res = '0;
    res.out_byte = beat.cover_byte;
    hit = 1'b0;
    base = int'(beat.cover_byte);
    if (beat.restart) last_out_byte = '0;
    if (beat.mode == MODE_EXTRACT) begin
      res.read_bit = key_entry(base);
    end else if (key_entry(base) != beat.message_bit) begin
      // Outward search, upward candidate first at each distance.
      for (k = 1; k <= dts_pkg::MAX_DIST && !hit &&
                  (base + k <= dts_pkg::BYTE_MAX || k <= base); k++) begin
        if (base + k <= dts_pkg::BYTE_MAX && key_entry(base + k) == beat.message_bit) begin
          res.out_byte = BYTE_W'(base + k);
          hit = 1'b1;
        end else if (k <= base && key_entry(base - k) == beat.message_bit) begin
          res.out_byte = BYTE_W'(base - k);
          hit = 1'b1;
        end
      end
      res.changed = hit;
      res.failed  = !hit;
    end
    last_out_byte = res.out_byte;
    return res;
  endfunction

  function automatic cover_beat_t random_beat();
    cover_beat_t beat;
    beat.mode        = ($urandom_range(0, 9) < 7) ? MODE_EMBED : MODE_EXTRACT;
    beat.restart     = ($urandom_range(0, 19) == 0);
    beat.cover_byte  = ($urandom_range(0, 7) == 0) ? {BYTE_W{$urandom_range(0, 1) == 1}}
                                                    : BYTE_W'($urandom);
    beat.message_bit = 1'($urandom_range(0, 1));
    return beat;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Offers one beat, with an optional random gap first, and records its result.
  task automatic send_beat(input cover_beat_t beat, input bit typed, input stego_result_t typed_res);
    int gap;
    stego_result_t predicted;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) gap = $urandom_range(1, 16);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       = 1'b1;
    in_ch.mode        = beat.mode;
    in_ch.restart     = beat.restart;
    in_ch.cover_byte  = beat.cover_byte;
    in_ch.message_bit = beat.message_bit;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predicted = predict_stego(beat);
    expected_results.push_back(typed ? typed_res : predicted);
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_key_word(input logic [CFG_INDEX_W-1:0] index,
                                input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    @(posedge clk);
    if (int'(index) < KEY_WORDS) key_table[int'(index) * WORD_W +: WORD_W] = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Writes all key words for a pattern, plus one write to an unused index.
  task automatic load_key(input key_pattern_t pattern);
    logic [WORD_W-1:0] word;
    int w;
    for (w = 0; w < KEY_WORDS; w++) begin
      case (pattern)
        KEY_ZERO:      word = '0;
        KEY_ONES:      word = '1;
        KEY_ALTERNATE: word = {(WORD_W / 2){2'b10}};
        KEY_LOWEST:    word = (w == 0) ? WORD_W'(1) : '0;
        KEY_HIGHEST:   word = (w == KEY_WORDS - 1) ? (WORD_W'(1) << (WORD_W - 2)) : '0;
        KEY_SPARSE:    word = {$urandom, $urandom} & {$urandom, $urandom} &
                              {$urandom, $urandom} & {$urandom, $urandom};
        KEY_DENSE:     word = {$urandom, $urandom} | {$urandom, $urandom} |
                              {$urandom, $urandom} | {$urandom, $urandom};
        default:       word = {$urandom, $urandom};
      endcase
      write_key_word(CFG_INDEX_W'(w), word);
    end
    write_key_word(CFG_INDEX_W'($urandom_range(KEY_WORDS, 2 ** CFG_INDEX_W - 1)),
                   {$urandom, $urandom});
  endtask

  // Result side ready: random stall bursts, and a long hold-off on request.
  initial begin : result_ready_driver
    int burst;
    burst = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      if (burst == 0 && idle_pct != 0 && $urandom_range(0, 99) < idle_pct / 4 + 1)
        burst = $urandom_range(1, 16);
      if (burst != 0) begin
        out_ch.ready = 1'b0;
        burst--;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest expectation, field by field.
  always @(posedge clk) begin : result_check
    stego_result_t want;
    if (rst === 1'b0 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = expected_results.pop_front();
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %0d, expected %0d", out_ch.out_byte, want.out_byte));
        if (out_ch.read_bit !== want.read_bit)
          report_mismatch($sformatf("read_bit %b, expected %b", out_ch.read_bit, want.read_bit));
        if (out_ch.changed !== want.changed)
          report_mismatch($sformatf("changed %b, expected %b", out_ch.changed, want.changed));
        if (out_ch.failed !== want.failed)
          report_mismatch($sformatf("failed %b, expected %b", out_ch.failed, want.failed));
      end
    end
  end

  // Watchdog on the total run length.
  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Main sequence: reset, directed rows, then the random phases.
  initial begin : stimulus
    key_pattern_t current_key;
    cover_beat_t beat;
    int r;
    int p;
    int n;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_EMBED;
    in_ch.restart     = 1'b0;
    in_ch.cover_byte  = '0;
    in_ch.message_bit = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // Directed part; the key table is all zero straight after reset.
    current_key = KEY_ZERO;
    for (r = 0; r < NUM_ROWS; r++) begin
      if (directed_rows[r].key != current_key) begin
        drain_results();
        current_key = directed_rows[r].key;
        load_key(current_key);
      end
      beat.mode        = directed_rows[r].mode;
      beat.restart     = directed_rows[r].restart;
      beat.cover_byte  = directed_rows[r].cover_byte;
      beat.message_bit = directed_rows[r].message_bit;
      send_beat(beat, directed_rows[r].typed, directed_rows[r].result);
    end

    // Random part, one key setting per phase.
    for (p = 0; p < NUM_PHASES; p++) begin
      drain_results();
      idle_pct = phase_plan[p].idle_pct;
      load_key(phase_plan[p].key);
      for (n = 0; n < phase_plan[p].beats; n++) begin
        if (p == PRESSURE_PHASE && n == 50) hold_off_req = 1'b1;
        if (p == PRESSURE_PHASE && n == 100) drain_results();
        send_beat(random_beat(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
